// ----- hdl/bracket_match_checker_top_macros.svh -----
// Assertion macros used by bmc_back, the checker's back end.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef BRACKET_MATCH_CHECKER_TOP_MACROS_SVH
`define BRACKET_MATCH_CHECKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMC_ASSERT_SAME(lbl, ante, cons, msg)
`define BMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/bmc_pkg.sv -----
package bmc_pkg;

    localparam int COL_W   = 12;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = KIND_W + COL_W;

    // request types
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_EOL  = 2'd1;
    localparam logic [1:0] REQ_EOS  = 2'd2;

    // bracket kinds
    localparam logic [KIND_W-1:0] KIND_PAREN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRACE = 2'd2;

    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;

    // depth of the queue between front and back; a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_FLUSH = 2'd2
    } op_code_t;

    typedef struct packed {
        op_code_t              code;
        logic [KIND_W-1:0]     kind;
        logic [CHAR_W-1:0]     ch;
        logic [COL_W-1:0]      col;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_opener(input logic [CHAR_W-1:0] c);
        return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
    endfunction

    function automatic logic is_closer(input logic [CHAR_W-1:0] c);
        return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
    endfunction

    function automatic logic [KIND_W-1:0] bracket_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        k = KIND_PAREN;
        if ((c == CH_LBRACK) || (c == CH_RBRACK)) k = KIND_BRACK;
        if ((c == CH_LBRACE) || (c == CH_RBRACE)) k = KIND_BRACE;
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] opener_char(input logic [KIND_W-1:0] k);
        logic [CHAR_W-1:0] c;
        unique case (k)
            KIND_BRACK: c = CH_LBRACK;
            KIND_BRACE: c = CH_LBRACE;
            default:    c = CH_LPAREN;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/bracket_match_checker_top.sv -----
// Bracket nesting checker for a character stream.
// Item channel (item_valid/item_ready): one transfer per character, end of
// line or end of stream, with req_type, ch and column. Result channel
// (result_valid/result_ready): one transfer per reported bracket, with
// err_column, err_char, no_error, overflow and last; last marks the final
// result that one item causes.
// The front classifies characters and tracks comments; classified bracket
// and end-of-stream operations wait in a four-entry queue for the back,
// which owns the stack store and the result register.
// A lone closer reports through the queue slot and result register; a
// mismatch also needs the registered stack read, then gives two results,
// opener first. Items transfer one per cycle while the queue has room; the
// back handles an opener in its idle state, a matching closer also in the
// compare state, a mismatching closer also in the mismatch state. End of
// stream reads first, then emits one opener per cycle unless stalled.
// Reset clears the comment state, the stack count, the queue and the
// sticky flags; the stack store itself is not cleared, so no clearing pass.
// When the receiver stalls the result register holds and the back waits;
// items keep transferring until the queue fills, then item_ready drops.
module bracket_match_checker_top
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 32,
    parameter int LINE_LENGTH = 4096
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          req_type,
    input  logic [CHAR_W-1:0]   ch,
    input  logic [COL_W-1:0]    column,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [COL_W-1:0]    err_column,
    output logic [CHAR_W-1:0]   err_char,
    output logic                no_error,
    output logic                overflow,
    output logic                last
);

    q_stat_t q_stat;
    logic    q_push, q_pop;
    op_t     q_data, q_head;

    // classify and skip comments
    bmc_front #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .req_type   (req_type),
        .ch         (ch),
        .column     (column),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    // decouple front from back
    bmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // stack, matching and result register
    bmc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .err_column   (err_column),
        .err_char     (err_char),
        .no_error     (no_error),
        .overflow     (overflow),
        .last         (last)
    );

endmodule

// ----- hdl/bmc_front.sv -----
module bmc_front
    import bmc_pkg::*;
#(
    parameter int LINE_LENGTH = 4096
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          req_type,
    input  logic [CHAR_W-1:0]   ch,
    input  logic [COL_W-1:0]    column,
    input  q_stat_t             q_stat,
    output logic                q_push,
    output op_t                 q_data
);

    logic prev_slash_reg, prev_slash_next;
    logic prev_star_reg, prev_star_next;
    logic line_cmt_reg, line_cmt_next;
    logic block_cmt_reg, block_cmt_next;
    logic accept;
    logic [COL_W-1:0] col_clamped;

    assign item_ready = !q_stat.full;
    assign accept     = item_valid && item_ready;

    // clamp columns past the line length
    always_comb
    begin
        if ({20'd0, column} >= 32'(LINE_LENGTH))
            col_clamped = COL_W'(LINE_LENGTH - 1);
        else
            col_clamped = column;
    end

    always_comb
    begin
        prev_slash_next = prev_slash_reg;
        prev_star_next  = prev_star_reg;
        line_cmt_next   = line_cmt_reg;
        block_cmt_next  = block_cmt_reg;
        q_push          = 1'b0;
        q_data.code     = OP_PUSH;
        q_data.kind     = bracket_kind(ch);
        q_data.ch       = ch;
        q_data.col      = col_clamped;
        if (accept)
        begin
            unique case (req_type)
                REQ_CHAR:
                begin
                    if (!line_cmt_reg)
                    begin
                        priority if (block_cmt_reg)
                        begin
                            if (prev_star_reg && (ch == CH_SLASH))
                            begin
                                block_cmt_next  = 1'b0;
                                prev_star_next  = 1'b0;
                                prev_slash_next = 1'b0;
                            end
                            else
                            begin
                                prev_star_next = (ch == CH_STAR);
                            end
                        end
                        else if (prev_slash_reg && (ch == CH_SLASH))
                        begin
                            line_cmt_next   = 1'b1;
                            prev_slash_next = 1'b0;
                        end
                        else if (prev_slash_reg && (ch == CH_STAR))
                        begin
                            block_cmt_next  = 1'b1;
                            prev_slash_next = 1'b0;
                            prev_star_next  = 1'b0;
                        end
                        else
                        begin
                            if (is_opener(ch))
                            begin
                                q_push      = 1'b1;
                                q_data.code = OP_PUSH;
                            end
                            else if (is_closer(ch))
                            begin
                                q_push      = 1'b1;
                                q_data.code = OP_CLOSE;
                            end
                            prev_slash_next = (ch == CH_SLASH);
                        end
                    end
                end
                REQ_EOL:
                begin
                    line_cmt_next   = 1'b0;
                    prev_slash_next = 1'b0;
                    prev_star_next  = 1'b0;
                end
                REQ_EOS:
                begin
                    q_push          = 1'b1;
                    q_data.code     = OP_FLUSH;
                    line_cmt_next   = 1'b0;
                    block_cmt_next  = 1'b0;
                    prev_slash_next = 1'b0;
                    prev_star_next  = 1'b0;
                end
                default:
                begin
                    // unused request type: drop
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_slash_reg <= 1'b0;
            prev_star_reg  <= 1'b0;
            line_cmt_reg   <= 1'b0;
            block_cmt_reg  <= 1'b0;
        end
        else
        begin
            prev_slash_reg <= prev_slash_next;
            prev_star_reg  <= prev_star_next;
            line_cmt_reg   <= line_cmt_next;
            block_cmt_reg  <= block_cmt_next;
        end
    end

endmodule

// ----- hdl/bmc_queue.sv -----
module bmc_queue
    import bmc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_data,
    input  logic    pop,
    output op_t     head,
    output q_stat_t stat
);

    op_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/bmc_back.sv -----
`include "bracket_match_checker_top_macros.svh"

module bmc_back
    import bmc_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)(
    input  logic                clk,
    input  logic                rst_n,
    input  op_t                 head,
    input  q_stat_t             q_stat,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [COL_W-1:0]    err_column,
    output logic [CHAR_W-1:0]   err_char,
    output logic                no_error,
    output logic                overflow,
    output logic                last
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_MISM  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next, cnt_dec;
    logic                err_seen_reg, err_seen_next;
    logic                ovf_seen_reg, ovf_seen_next;
    op_t                 cur_reg, cur_next;

    logic [ENTRY_W-1:0]  stack_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                mem_we, rd_en;
    logic [KIND_W-1:0]   rd_kind;
    logic [COL_W-1:0]    rd_col;

    logic                out_valid_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_noerr_reg, out_ovf_reg, out_last_reg;
    logic                out_free, emit;
    logic [COL_W-1:0]    em_col;
    logic [CHAR_W-1:0]   em_char;
    logic                em_noerr, em_last;

    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign rd_kind  = rd_data_reg[ENTRY_W-1:COL_W];
    assign rd_col   = rd_data_reg[COL_W-1:0];
    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        err_seen_next = err_seen_reg;
        ovf_seen_next = ovf_seen_reg;
        cur_next      = cur_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        emit          = 1'b0;
        em_col        = '0;
        em_char       = '0;
        em_noerr      = 1'b0;
        em_last       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (head.code)
                        OP_PUSH:
                        begin
                            q_pop = 1'b1;
                            if (cnt_reg < CNT_W'(STACK_DEPTH))
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_seen_next = 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                if (out_free)
                                begin
                                    q_pop         = 1'b1;
                                    emit          = 1'b1;
                                    em_col        = head.col;
                                    em_char       = head.ch;
                                    em_last       = 1'b1;
                                    err_seen_next = 1'b1;
                                end
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                rd_en      = 1'b1;
                                cnt_next   = cnt_dec;
                                cur_next   = head;
                                state_next = ST_CMP;
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                if (out_free)
                                begin
                                    q_pop         = 1'b1;
                                    emit          = 1'b1;
                                    em_noerr      = !err_seen_reg;
                                    em_last       = 1'b1;
                                    err_seen_next = 1'b0;
                                    ovf_seen_next = 1'b0;
                                end
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                rd_en      = 1'b1;
                                cnt_next   = cnt_dec;
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (rd_kind == cur_reg.kind)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit          = 1'b1;
                    em_col        = rd_col;
                    em_char       = opener_char(rd_kind);
                    err_seen_next = 1'b1;
                    state_next    = ST_MISM;
                end
            end
            ST_MISM:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    em_col     = cur_reg.col;
                    em_char    = cur_reg.ch;
                    em_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    em_col  = rd_col;
                    em_char = opener_char(rd_kind);
                    if (cnt_reg == '0)
                    begin
                        em_last       = 1'b1;
                        err_seen_next = 1'b0;
                        ovf_seen_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        cnt_next = cnt_dec;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            err_seen_reg  <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            err_seen_reg <= err_seen_next;
            ovf_seen_reg <= ovf_seen_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_col_reg   <= em_col;
            out_char_reg  <= em_char;
            out_noerr_reg <= em_noerr;
            out_ovf_reg   <= ovf_seen_reg;
            out_last_reg  <= em_last;
        end
    end

    // stack store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[cnt_reg[IDX_W-1:0]] <= {head.kind, head.col};
        if (rd_en)
            rd_data_reg <= stack_mem[cnt_dec[IDX_W-1:0]];
    end

    assign result_valid = out_valid_reg;
    assign err_column   = out_col_reg;
    assign err_char     = out_char_reg;
    assign no_error     = out_noerr_reg;
    assign overflow     = out_ovf_reg;
    assign last         = out_last_reg;

    `BMC_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(STACK_DEPTH), "stack count past depth")
    `BMC_ASSERT_SAME(a_noerr_last, out_valid_reg && out_noerr_reg, out_last_reg, "no_error on a non-final result")
    `BMC_ASSERT_NEXT(a_mism_done, (state_reg == ST_MISM) && out_free, (state_reg == ST_IDLE) && out_valid_reg && out_last_reg, "mismatch pair not closed")
    `BMC_ASSERT_NEXT(a_flush_end, (state_reg == ST_FLUSH) && out_free && (cnt_reg == '0), !err_seen_reg && !ovf_seen_reg, "flags not cleared after flush")

endmodule

// ----- tb/sv/bracket_match_checker_top_test.sv -----
`timescale 1ns / 100ps

// An initial block builds the whole character stream up front (a short
// directed part, then random streams) into a queue. A clocked driver
// presents that queue on the item channel in bursts, changing inputs at
// the falling edge. A clocked monitor samples both channels at the rising
// edge. Every item transfer runs through a local bracket tracker, which
// queues the reports the block must produce. Every result transfer is
// compared field by field against the oldest queued report.
module bracket_match_checker_top_test;
    import bmc_pkg::*;

    localparam int STACK_SLOTS = 32;
    localparam int QUIET_LIMIT = 4000;
    localparam int FEED_TARGET = 400;
    localparam int SETTLE_CYCLES = 20;

    // request code the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // one item of the character stream; drain holds the item back until
    // every outstanding report has been received
    typedef struct {
        logic [1:0]        req;
        logic [CHAR_W-1:0] chr;
        logic [COL_W-1:0]  col;
        bit                drain;
    } feed_t;

    typedef struct {
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] chr;
        logic              ok;
        logic              ovf;
        logic              fin;
    } report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    logic [1:0]          req_type = REQ_CHAR;
    logic [CHAR_W-1:0]   ch = '0;
    logic [COL_W-1:0]    column = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic [COL_W-1:0]    err_column;
    logic [CHAR_W-1:0]   err_char;
    logic                no_error;
    logic                overflow;
    logic                last;

    feed_t   text_feed[$];
    report_t due_reports[$];

    // tracker state: a copy of the nesting stack and comment flags
    logic [KIND_W-1:0] nest_kind [STACK_SLOTS];
    logic [COL_W-1:0]  nest_col [STACK_SLOTS];
    int unsigned       nest_depth = 0;
    bit after_slash = 1'b0;
    bit after_star = 1'b0;
    bit line_cmt = 1'b0;
    bit block_cmt = 1'b0;
    bit saw_error = 1'b0;
    bit saw_overflow = 1'b0;

    logic        item_fire = 1'b0;
    int unsigned fault_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    logic [15:0] cycle_cnt = '0;

    bracket_match_checker_top #(
        .STACK_DEPTH (STACK_SLOTS),
        .LINE_LENGTH (4096)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .req_type     (req_type),
        .ch           (ch),
        .column       (column),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .err_column   (err_column),
        .err_char     (err_char),
        .no_error     (no_error),
        .overflow     (overflow),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] opener_of(input logic [KIND_W-1:0] k);
        unique case (k)
            KIND_BRACK: return CH_LBRACK;
            KIND_BRACE: return CH_LBRACE;
            default:    return CH_LPAREN;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] closer_of(input logic [KIND_W-1:0] k);
        unique case (k)
            KIND_BRACK: return CH_RBRACK;
            KIND_BRACE: return CH_RBRACE;
            default:    return CH_RPAREN;
        endcase
    endfunction

    function automatic void post_report(input logic [COL_W-1:0] col,
                                        input logic [CHAR_W-1:0] c, input logic ok);
        report_t r;
        r.col = col;
        r.chr = c;
        r.ok  = ok;
        r.ovf = saw_overflow;
        r.fin = 1'b0;
        due_reports.push_back(r);
    endfunction

    // Advance the tracker by one transferred item and queue its reports.
    function automatic void bracket_reports(input feed_t it);
        int unsigned       first_new;
        bit                is_open;
        bit                is_close;
        logic [KIND_W-1:0] k;

        first_new = due_reports.size();
        is_open   = 1'b0;
        is_close  = 1'b0;
        k         = KIND_PAREN;
        unique case (it.chr)
            CH_LPAREN:
            begin
                is_open = 1'b1;
                k       = KIND_PAREN;
            end
            CH_LBRACK:
            begin
                is_open = 1'b1;
                k       = KIND_BRACK;
            end
            CH_LBRACE:
            begin
                is_open = 1'b1;
                k       = KIND_BRACE;
            end
            CH_RPAREN:
            begin
                is_close = 1'b1;
                k        = KIND_PAREN;
            end
            CH_RBRACK:
            begin
                is_close = 1'b1;
                k        = KIND_BRACK;
            end
            CH_RBRACE:
            begin
                is_close = 1'b1;
                k        = KIND_BRACE;
            end
            default: ;
        endcase

        unique case (it.req)
            REQ_CHAR:
            begin
                if (line_cmt)
                begin
                    // skip everything up to the end of line
                end
                else if (block_cmt)
                begin
                    if (after_star && it.chr == CH_SLASH)
                    begin
                        block_cmt   = 1'b0;
                        after_star  = 1'b0;
                        after_slash = 1'b0;
                    end
                    else
                    begin
                        after_star = (it.chr == CH_STAR);
                    end
                end
                else if (after_slash && it.chr == CH_SLASH)
                begin
                    line_cmt    = 1'b1;
                    after_slash = 1'b0;
                end
                else if (after_slash && it.chr == CH_STAR)
                begin
                    block_cmt   = 1'b1;
                    after_slash = 1'b0;
                    after_star  = 1'b0;
                end
                else
                begin
                    if (is_open)
                    begin
                        if (nest_depth < STACK_SLOTS)
                        begin
                            nest_kind[nest_depth] = k;
                            nest_col[nest_depth]  = it.col;
                            nest_depth++;
                        end
                        else
                        begin
                            saw_overflow = 1'b1;
                        end
                    end
                    else if (is_close)
                    begin
                        if (nest_depth == 0)
                        begin
                            saw_error = 1'b1;
                            post_report(it.col, it.chr, 1'b0);
                        end
                        else
                        begin
                            nest_depth--;
                            if (nest_kind[nest_depth] != k)
                            begin
                                saw_error = 1'b1;
                                post_report(nest_col[nest_depth],
                                            opener_of(nest_kind[nest_depth]), 1'b0);
                                post_report(it.col, it.chr, 1'b0);
                            end
                        end
                    end
                    after_slash = (it.chr == CH_SLASH);
                end
            end
            REQ_EOL:
            begin
                line_cmt    = 1'b0;
                after_slash = 1'b0;
                after_star  = 1'b0;
            end
            REQ_EOS:
            begin
                if (nest_depth == 0)
                begin
                    post_report('0, '0, !saw_error);
                end
                else
                begin
                    while (nest_depth > 0)
                    begin
                        nest_depth--;
                        post_report(nest_col[nest_depth], opener_of(nest_kind[nest_depth]),
                                    1'b0);
                    end
                end
                after_slash  = 1'b0;
                after_star   = 1'b0;
                line_cmt     = 1'b0;
                block_cmt    = 1'b0;
                saw_error    = 1'b0;
                saw_overflow = 1'b0;
            end
            default: ;
        endcase

        if (due_reports.size() > first_new)
            due_reports[due_reports.size() - 1].fin = 1'b1;
    endfunction

    function automatic void add_feed(input logic [1:0] req, input logic [CHAR_W-1:0] c,
                                     input logic [COL_W-1:0] col);
        feed_t f;
        f.req   = req;
        f.chr   = c;
        f.col   = col;
        f.drain = 1'b0;
        text_feed.push_back(f);
    endfunction

    // Build one random stream ending in end of stream. Most streams are
    // lines of plausible code; some nest past the stack depth; some are noise.
    function automatic void gen_text_stream(input int style);
        logic [KIND_W-1:0] open_kinds[$];
        int unsigned       n_lines;
        int unsigned       n_chars;
        int unsigned       r;
        logic [COL_W-1:0]  col;
        logic [KIND_W-1:0] k;

        if (style == 0)
        begin
            // nest past the stack depth, then flush
            n_chars = $urandom_range(STACK_SLOTS + 1, STACK_SLOTS + 6);
            col = COL_W'($urandom_range(0, 4095));
            for (int unsigned i = 0; i < n_chars; i++)
            begin
                k = KIND_W'($urandom_range(0, 2));
                add_feed(REQ_CHAR, opener_of(k), col);
                col++;
            end
        end
        else if (style == 1)
        begin
            // noise: any request code, any byte, any column
            n_chars = $urandom_range(8, 24);
            for (int unsigned i = 0; i < n_chars; i++)
            begin
                r = $urandom_range(0, 9);
                if (r < 3)
                begin
                    add_feed(2'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                             COL_W'($urandom_range(0, 4095)));
                end
                else if (r < 5)
                begin
                    add_feed(REQ_CHAR, ($urandom_range(0, 1) != 0) ? CH_SLASH : CH_STAR,
                             COL_W'($urandom_range(0, 4095)));
                end
                else
                begin
                    k = KIND_W'($urandom_range(0, 2));
                    add_feed(REQ_CHAR, ($urandom_range(0, 1) != 0) ? opener_of(k)
                                                                 : closer_of(k),
                             COL_W'($urandom_range(0, 4095)));
                end
            end
        end
        else
        begin
            n_lines = $urandom_range(1, 4);
            for (int unsigned l = 0; l < n_lines; l++)
            begin
                col = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(0, 4095)) : '0;
                n_chars = $urandom_range(0, 12);
                for (int unsigned i = 0; i < n_chars; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 30)
                    begin
                        k = KIND_W'($urandom_range(0, 2));
                        open_kinds.push_back(k);
                        add_feed(REQ_CHAR, opener_of(k), col);
                    end
                    else if (r < 55 && open_kinds.size() != 0)
                    begin
                        k = open_kinds.pop_back();
                        add_feed(REQ_CHAR, closer_of(k), col);
                    end
                    else if (r < 60)
                        add_feed(REQ_CHAR, closer_of(KIND_W'($urandom_range(0, 2))), col);
                    else if (r < 70)
                        add_feed(REQ_CHAR, CH_SLASH, col);
                    else if (r < 75)
                        add_feed(REQ_CHAR, CH_STAR, col);
                    else
                        add_feed(REQ_CHAR, CHAR_W'($urandom_range(0, 255)), col);
                    col++;
                end
                add_feed(REQ_EOL, CHAR_W'($urandom_range(0, 255)),
                         COL_W'($urandom_range(0, 4095)));
            end
            // usually close what is still open so clean streams occur
            if ($urandom_range(0, 3) != 0)
            begin
                col = COL_W'($urandom_range(0, 4000));
                while (open_kinds.size() != 0)
                begin
                    k = open_kinds.pop_back();
                    add_feed(REQ_CHAR, closer_of(k), col);
                    col++;
                end
            end
        end
        add_feed(REQ_EOS, CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 4095)));
    endfunction

    // Driver: present the next queued item at the falling edge once the
    // current one has transferred; pace the sender in bursts and gaps and
    // pattern the receiver's ready in four phases set by the cycle counter.
    always @(negedge clk)
    begin : drive_block
        feed_t nxt;
        if (rst_n)
        begin
            if (!item_valid || item_fire)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (text_feed.size() == 0 ||
                         (text_feed[0].drain && due_reports.size() != 0))
                begin
                    // hold a draining item until every report is in
                    item_valid <= 1'b0;
                end
                else
                begin
                    nxt = text_feed.pop_front();
                    item_valid <= 1'b1;
                    req_type   <= nxt.req;
                    ch         <= nxt.chr;
                    column     <= nxt.col;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            unique case (cycle_cnt[8:7])
                2'd0:    result_ready <= 1'b1;
                2'd1:    result_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    result_ready <= ($urandom_range(0, 3) == 0);
                default: result_ready <= (cycle_cnt[2:0] != 3'd5) && (cycle_cnt[4:3] != 2'd2);
            endcase
            cycle_cnt++;
        end
    end

    // Monitor: track each item transfer and check each result transfer.
    always @(posedge clk)
    begin : watch_block
        feed_t   seen;
        report_t want;
        if (rst_n)
        begin
            item_fire <= item_valid && item_ready;
            if (item_valid && item_ready)
            begin
                seen.req   = req_type;
                seen.chr   = ch;
                seen.col   = column;
                seen.drain = 1'b0;
                bracket_reports(seen);
            end
            if (result_valid && result_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result: col=%0d chr=%h ok=%b ovf=%b last=%b",
                                 err_column, err_char, no_error, overflow, last);
                    fault_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (err_column !== want.col || err_char !== want.chr ||
                        no_error !== want.ok || overflow !== want.ovf || last !== want.fin)
                    begin
                        if (fault_count < 10)
                        begin
                            $write("result mismatch: expected col=%0d chr=%h ok=%b ovf=%b ",
                                   want.col, want.chr, want.ok, want.ovf);
                            $display("last=%b, got col=%0d chr=%h ok=%b ovf=%b last=%b",
                                     want.fin, err_column, err_char, no_error, overflow,
                                     last);
                        end
                        fault_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned stream_no;
        int unsigned first_idx;

        // Directed part: field extremes, pop on match, mismatch, comments.
        add_feed(REQ_CHAR, CH_LPAREN, 12'd0);
        add_feed(REQ_CHAR, CH_LBRACK, 12'd4095);
        add_feed(REQ_CHAR, CH_LBRACE, 12'd2048);
        add_feed(REQ_CHAR, CH_RBRACE, 12'd1);      // pops the brace
        add_feed(REQ_CHAR, CH_RPAREN, 12'd7);      // meets the bracket: two reports
        // line comment hides the opener, end of line closes it
        add_feed(REQ_CHAR, CH_SLASH, 12'd8);
        add_feed(REQ_CHAR, CH_SLASH, 12'd9);
        add_feed(REQ_CHAR, CH_LPAREN, 12'd10);
        add_feed(REQ_EOL, 8'hFF, 12'd4095);
        // the star of a comment opener cannot also close it; the comment
        // runs across end of line; the closing slash starts nothing new
        add_feed(REQ_CHAR, CH_SLASH, 12'd0);
        add_feed(REQ_CHAR, CH_STAR, 12'd1);
        add_feed(REQ_CHAR, CH_SLASH, 12'd2);
        add_feed(REQ_EOL, 8'h00, 12'd0);
        add_feed(REQ_CHAR, CH_STAR, 12'd0);
        add_feed(REQ_CHAR, CH_SLASH, 12'd1);
        add_feed(REQ_CHAR, CH_STAR, 12'd2);
        add_feed(REQ_CHAR, CH_RPAREN, 12'd4095);   // pops the first paren
        // a pending slash is forgotten at end of line
        add_feed(REQ_CHAR, CH_SLASH, 12'd3);
        add_feed(REQ_EOL, 8'h55, 12'hAAA);
        add_feed(REQ_CHAR, CH_SLASH, 12'd0);
        add_feed(REQ_CHAR, CH_RBRACK, 12'h555);    // closer on an empty stack
        add_feed(REQ_CHAR, 8'hFF, 12'hFFF);
        add_feed(REQ_UNUSED, CH_LPAREN, 12'd5);    // ignored request code
        add_feed(REQ_EOS, 8'h00, 12'd0);           // error was seen
        add_feed(REQ_CHAR, CH_LBRACE, 12'd4094);
        text_feed[text_feed.size() - 1].drain = 1'b1;
        add_feed(REQ_EOS, 8'hAA, 12'h555);         // flushes the lone opener
        add_feed(REQ_EOS, 8'h55, 12'hAAA);         // clean stream

        // Random part: open with an overflowing stream, then mostly code.
        stream_no = 0;
        while (text_feed.size() < FEED_TARGET)
        begin
            first_idx = text_feed.size();
            if (stream_no == 0 || $urandom_range(0, 19) == 0)
                gen_text_stream(0);
            else if ($urandom_range(0, 4) == 0)
                gen_text_stream(1);
            else
                gen_text_stream(2);
            if (stream_no % 4 == 3)
                text_feed[first_idx].drain = 1'b1;
            stream_no++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: wait for the last transfer and every report, then settle.
        do
            @(posedge clk);
        while (text_feed.size() != 0 || item_valid || due_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0 && due_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
